### design/gpb_pkg.sv
// ----------------------------------------------------------------------------
// gpb_pkg
// Shared constants for the grayscale posterize and blend pixel unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gpb_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PIXEL_FORMAT      = 2'd0,
    REG_GRAY_LEVELS       = 2'd1,
    REG_SMOOTH_MODE       = 2'd2,
    REG_INTENSITY_PERCENT = 2'd3
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  // pixel formats
  localparam logic FMT_RGB888 = 1'b0;
  localparam logic FMT_RGB565 = 1'b1;

  // register reset values
  localparam logic       RstPixelFormat = FMT_RGB888;
  localparam logic [8:0] RstGrayLevels  = 9'd2;
  localparam logic       RstSmoothMode  = 1'b1;
  localparam logic [6:0] RstIntensity   = 7'd100;

  // luma weights
  localparam logic [11:0] CoefR = 12'd872;
  localparam logic [11:0] CoefG = 12'd2930;
  localparam logic [11:0] CoefB = 12'd296;

  localparam int unsigned LumaSumW = 20;
  localparam int unsigned RecipW   = 17;
  localparam int unsigned StepW    = 9;
  localparam int unsigned KW       = 7;
  localparam int unsigned BlendW   = 14;

  localparam logic [KW-1:0] KFull     = 7'd64;
  localparam logic [7:0]    GrayMax   = 8'd255;
  localparam logic [8:0]    LevelsMax = 9'd256;
  localparam logic [8:0]    LevelsMin = 9'd2;

  // derived values for the reset configuration
  localparam logic [7:0]        RstGroup = 8'd128;
  localparam logic [RecipW-1:0] RstRecip = 17'd512;
  localparam logic [StepW-1:0]  RstStep  = 9'd256;
  localparam logic [7:0]        RstLvm1  = 8'd1;

endpackage

`default_nettype wire

### design/grayscale_posterize_blend.sv
// ----------------------------------------------------------------------------
// grayscale_posterize_blend
// Pixel pipeline: luma, optional posterize, blend of gray over the color.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        sink       in_valid_i / in_stall_o   in_red/green/blue, in_rgb565
//  out       source     out_valid_o / out_stall_i out_red/green/blue, out_rgb565
//  cfg       sink       cfg_we_i                  cfg_idx_i, cfg_data_i
//
//  six register stages, one pixel per cycle while the output is not stalled
//  the rate is set by the pipeline: every stage advances together
//  a stall on the output freezes all stages; a bubble in the output slot is
//  filled even while stalled
//  reset clears the valid bits and loads the register reset values
// ----------------------------------------------------------------------------
`default_nettype none

module grayscale_posterize_blend (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gpb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gpb_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    in_red_i,
  input  logic [7:0]                    in_green_i,
  input  logic [7:0]                    in_blue_i,
  input  logic [15:0]                   in_rgb565_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_red_o,
  output logic [7:0]                    out_green_o,
  output logic [7:0]                    out_blue_o,
  output logic [15:0]                   out_rgb565_o
);

  localparam int unsigned NumStages = 6;

  // configuration registers
  logic       fmt_q;
  logic [8:0] levels_q;
  logic       smooth_q;
  logic [6:0] pct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= gpb_pkg::RstPixelFormat;
      levels_q <= gpb_pkg::RstGrayLevels;
      smooth_q <= gpb_pkg::RstSmoothMode;
      pct_q    <= gpb_pkg::RstIntensity;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gpb_pkg::REG_PIXEL_FORMAT:      fmt_q    <= cfg_data_i[0];
        gpb_pkg::REG_GRAY_LEVELS:       levels_q <= cfg_data_i[8:0];
        gpb_pkg::REG_SMOOTH_MODE:       smooth_q <= cfg_data_i[0];
        gpb_pkg::REG_INTENSITY_PERCENT: pct_q    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // constant tables indexed by level count and percent
  logic [7:0]                  grp_tbl  [256];
  logic [gpb_pkg::RecipW-1:0]  rcp_tbl  [256];
  logic [gpb_pkg::StepW-1:0]   stp_tbl  [256];
  logic [7:0]                  lvm1_tbl [256];
  logic [gpb_pkg::KW-1:0]      k_tbl    [128];

  for (genvar i = 0; i < 256; i++) begin : g_lv_tbl
    localparam int unsigned Lv  = (i < 2) ? 2 : i;
    localparam int unsigned Grp = 256 / Lv;
    localparam int unsigned Rcp = 65536 / Grp;
    localparam int unsigned Stp = 256 / (Lv - 1);
    assign grp_tbl[i]  = 8'(Grp);
    assign rcp_tbl[i]  = gpb_pkg::RecipW'(Rcp);
    assign stp_tbl[i]  = gpb_pkg::StepW'(Stp);
    assign lvm1_tbl[i] = 8'(Lv - 1);
  end

  for (genvar i = 0; i < 128; i++) begin : g_k_tbl
    localparam int unsigned Pct = (i > 100) ? 100 : i;
    localparam int unsigned K   = (Pct * 64) / 100;
    assign k_tbl[i] = gpb_pkg::KW'(K);
  end

  // derived configuration, refreshed every cycle
  logic                        smooth_eff_q;
  logic [7:0]                  group_q;
  logic [gpb_pkg::RecipW-1:0]  recip_q;
  logic [gpb_pkg::StepW-1:0]   step_q;
  logic [7:0]                  lvm1_q;
  logic [gpb_pkg::KW-1:0]      k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_eff_q <= 1'b1;
      group_q      <= gpb_pkg::RstGroup;
      recip_q      <= gpb_pkg::RstRecip;
      step_q       <= gpb_pkg::RstStep;
      lvm1_q       <= gpb_pkg::RstLvm1;
      k_q          <= gpb_pkg::KFull;
    end else begin
      smooth_eff_q <= smooth_q || (levels_q >= gpb_pkg::LevelsMax);
      group_q      <= grp_tbl[levels_q[7:0]];
      recip_q      <= rcp_tbl[levels_q[7:0]];
      step_q       <= stp_tbl[levels_q[7:0]];
      lvm1_q       <= lvm1_tbl[levels_q[7:0]];
      k_q          <= k_tbl[pct_q];
    end
  end

  // pipeline control
  logic [NumStages-1:0] vld_q;
  logic                 advance;

  assign advance    = !vld_q[NumStages-1] || !out_stall_i;
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  // stage 1: channel select
  logic       fmt1_q, fmt2_q, fmt3_q, fmt4_q, fmt5_q;
  logic [7:0] r1_q, g1_q, b1_q;
  logic [7:0] r_sel, g_sel, b_sel;

  always_comb begin
    if (fmt_q == gpb_pkg::FMT_RGB565) begin
      r_sel = {in_rgb565_i[15:11], 3'b000};
      g_sel = {in_rgb565_i[10:5], 2'b00};
      b_sel = {in_rgb565_i[4:0], 3'b000};
    end else begin
      r_sel = in_red_i;
      g_sel = in_green_i;
      b_sel = in_blue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fmt1_q <= fmt_q;
      r1_q   <= r_sel;
      g1_q   <= g_sel;
      b1_q   <= b_sel;
    end
  end

  // stage 2: luma
  logic [7:0]                   r2_q, g2_q, b2_q, luma2_q;
  logic [gpb_pkg::LumaSumW-1:0] luma_sum;

  assign luma_sum = gpb_pkg::LumaSumW'(r1_q) * gpb_pkg::LumaSumW'(gpb_pkg::CoefR)
                  + gpb_pkg::LumaSumW'(g1_q) * gpb_pkg::LumaSumW'(gpb_pkg::CoefG)
                  + gpb_pkg::LumaSumW'(b1_q) * gpb_pkg::LumaSumW'(gpb_pkg::CoefB);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fmt2_q  <= fmt1_q;
      r2_q    <= r1_q;
      g2_q    <= g1_q;
      b2_q    <= b1_q;
      luma2_q <= luma_sum[gpb_pkg::LumaSumW-1:12];
    end
  end

  // stage 3: reciprocal estimate of luma / group
  logic [7:0]  r3_q, g3_q, b3_q, luma3_q, q3_q;
  logic [24:0] q_prod;

  assign q_prod = 25'(luma2_q) * 25'(recip_q);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fmt3_q  <= fmt2_q;
      r3_q    <= r2_q;
      g3_q    <= g2_q;
      b3_q    <= b2_q;
      luma3_q <= luma2_q;
      q3_q    <= q_prod[23:16];
    end
  end

  // stage 4: quotient correction
  logic [7:0]  r4_q, g4_q, b4_q, luma4_q, idx4_q;
  logic [15:0] q_back;
  logic [15:0] rem;
  logic [7:0]  idx;

  assign q_back = 16'(q3_q) * 16'(group_q);
  assign rem    = 16'(luma3_q) - q_back;
  assign idx    = (rem >= 16'(group_q)) ? 8'(q3_q + 8'd1) : q3_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fmt4_q  <= fmt3_q;
      r4_q    <= r3_q;
      g4_q    <= g3_q;
      b4_q    <= b3_q;
      luma4_q <= luma3_q;
      idx4_q  <= idx;
    end
  end

  // stage 5: gray level
  logic [7:0]  r5_q, g5_q, b5_q, gray5_q;
  logic [16:0] lvl_prod;
  logic [7:0]  gray;

  assign lvl_prod = 17'(idx4_q) * 17'(step_q);

  always_comb begin
    if (smooth_eff_q) begin
      gray = luma4_q;
    end else if (idx4_q >= lvm1_q) begin
      gray = gpb_pkg::GrayMax;
    end else begin
      gray = lvl_prod[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fmt5_q  <= fmt4_q;
      r5_q    <= r4_q;
      g5_q    <= g4_q;
      b5_q    <= b4_q;
      gray5_q <= gray;
    end
  end

  // stage 6: blend and pack
  logic [gpb_pkg::KW-1:0]     kc;
  logic [gpb_pkg::BlendW-1:0] gk, rb, gb, bb;
  logic [7:0]                 ro, go, bo;
  logic [7:0]                 red_d, green_d, blue_d;
  logic [15:0]                rgb565_d;
  logic [7:0]                 red_q, green_q, blue_q;
  logic [15:0]                rgb565_q;

  assign kc = gpb_pkg::KFull - k_q;
  assign gk = gpb_pkg::BlendW'(gray5_q) * gpb_pkg::BlendW'(k_q);
  assign rb = gk + gpb_pkg::BlendW'(r5_q) * gpb_pkg::BlendW'(kc);
  assign gb = gk + gpb_pkg::BlendW'(g5_q) * gpb_pkg::BlendW'(kc);
  assign bb = gk + gpb_pkg::BlendW'(b5_q) * gpb_pkg::BlendW'(kc);
  assign ro = rb[gpb_pkg::BlendW-1:6];
  assign go = gb[gpb_pkg::BlendW-1:6];
  assign bo = bb[gpb_pkg::BlendW-1:6];

  always_comb begin
    if (fmt5_q == gpb_pkg::FMT_RGB565) begin
      red_d    = '0;
      green_d  = '0;
      blue_d   = '0;
      rgb565_d = {ro[7:3], go[7:2], bo[7:3]};
    end else begin
      red_d    = ro;
      green_d  = go;
      blue_d   = bo;
      rgb565_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      red_q    <= red_d;
      green_q  <= green_d;
      blue_q   <= blue_d;
      rgb565_q <= rgb565_d;
    end
  end

  assign out_valid_o  = vld_q[NumStages-1];
  assign out_red_o    = red_q;
  assign out_green_o  = green_q;
  assign out_blue_o   = blue_q;
  assign out_rgb565_o = rgb565_q;

`ifndef ASSERT_OFF
  // corrected quotient is exact
  a_idx_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> ((16'(idx4_q) * 16'(group_q) <= 16'(luma4_q)) &&
                  (16'(luma4_q) < (16'(idx4_q) + 16'd1) * 16'(group_q))))
    else $error("posterize index off");

  // a stage that moves forward lands in the next one
  a_stage_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[2] && advance) |=> vld_q[3])
    else $error("pixel dropped in pipeline");

  // the unused half of the result is zero
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_rgb565_o == 16'd0) ||
                     (out_red_o == 8'd0 && out_green_o == 8'd0 && out_blue_o == 8'd0)))
    else $error("both result formats driven");

  // blend weight stays in range
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= gpb_pkg::KFull)
    else $error("blend weight out of range");
`endif

endmodule

`default_nettype wire
